FILE: src/tvs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Turtle vector stepper package
// Shared command codes, fixed-point widths, constants and the datapath
// command bundle used by the controller and the datapath.
// ----------------------------------------------------------------------------
package tvs_pkg;

    localparam int FRACTION_BITS = 8;

    localparam int OP_W  = 3;
    localparam int AMT_W = 24;
    localparam int HDG_W = 17;
    localparam int POS_W = 32;

    typedef enum logic [OP_W-1:0] {
        OP_RESET    = 3'd0,
        OP_CENTER   = 3'd1,
        OP_PEN_UP   = 3'd2,
        OP_PEN_DOWN = 3'd3,
        OP_TURN     = 3'd4,
        OP_MOVE     = 3'd5
    } t_op;

    // One full turn in heading units.
    localparam longint FULL_TURN = longint'(360) << FRACTION_BITS;

    // Heading reduction: a bias of a whole number of turns makes the sum
    // positive, then one conditional subtract of a scaled turn per step.
    localparam int     TURN_STEPS = 8;
    localparam int     TURN_K_W   = 3;
    localparam int     TURN_ACC_W = 25;
    localparam longint TURN_BIAS  = FULL_TURN << (TURN_STEPS - 1);

    // Heading to 32-bit binary angle by a reciprocal multiply and a
    // single correction step.
    localparam int     BAM_W       = 32;
    localparam int     RECIP_SHIFT = BAM_W + HDG_W;
    localparam longint RECIP       = (longint'(1) << RECIP_SHIFT) / FULL_TURN;
    localparam int     RECIP_W     = 33;
    localparam int     BPROD_W     = HDG_W + RECIP_W;
    localparam int     QFT_W       = BAM_W + HDG_W;

    // CORDIC vectors and angle accumulator.
    localparam int     CX_W         = 33;
    localparam int     ATAN_IDX_W   = 5;
    localparam int     ATAN_W       = 30;
    localparam longint CORDIC_START = 652032874;

    // Displacement multiply and rounding.
    localparam int MAMT_W      = AMT_W + 1;
    localparam int DPROD_W     = MAMT_W + CX_W;
    localparam int ROUND_SHIFT = 30;
    localparam int DX_W        = DPROD_W - ROUND_SHIFT;

    typedef struct packed {
        logic                load;
        logic                turn_init;
        logic                turn_step;
        logic [TURN_K_W-1:0] turn_k;
        logic                bam_mul;
        logic                bam_chk;
        logic                bam_fix;
        logic                rot_init;
        logic                rot_step;
        logic                mul_x;
        logic                mul_y;
        logic                add_x;
        logic                add_y;
        logic                out_load;
    } t_dp_cmd;

    // Arctangent of 2^-i in binary-angle units, rounded to nearest.
    function automatic logic [ATAN_W-1:0] atan_bam(input logic [ATAN_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 30'd536870912;
            5'd1:    v = 30'd316933406;
            5'd2:    v = 30'd167458907;
            5'd3:    v = 30'd85004756;
            5'd4:    v = 30'd42667331;
            5'd5:    v = 30'd21354465;
            5'd6:    v = 30'd10679838;
            5'd7:    v = 30'd5340245;
            5'd8:    v = 30'd2670163;
            5'd9:    v = 30'd1335087;
            5'd10:   v = 30'd667544;
            5'd11:   v = 30'd333772;
            5'd12:   v = 30'd166886;
            5'd13:   v = 30'd83443;
            5'd14:   v = 30'd41722;
            5'd15:   v = 30'd20861;
            5'd16:   v = 30'd10430;
            5'd17:   v = 30'd5215;
            5'd18:   v = 30'd2608;
            5'd19:   v = 30'd1304;
            5'd20:   v = 30'd652;
            5'd21:   v = 30'd326;
            5'd22:   v = 30'd163;
            5'd23:   v = 30'd81;
            5'd24:   v = 30'd41;
            5'd25:   v = 30'd20;
            5'd26:   v = 30'd10;
            5'd27:   v = 30'd5;
            5'd28:   v = 30'd3;
            5'd29:   v = 30'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: src/tvs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Turtle vector stepper controller
// Sequences each command through the datapath and owns the result valid flag.
// ----------------------------------------------------------------------------
module tvs_ctrl #(
    parameter int CORDIC_ITERATIONS = 16,
    localparam int ROT_W = $clog2(CORDIC_ITERATIONS)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    input  logic [tvs_pkg::OP_W-1:0] i_op,
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    output tvs_pkg::t_dp_cmd        o_cmd,
    output logic [ROT_W-1:0]        o_rot_idx
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_TINIT,
        S_TURN,
        S_BAM1,
        S_BAM2,
        S_BAM3,
        S_INIT,
        S_ROT,
        S_MULX,
        S_MULY,
        S_ADDY,
        S_FIN
    } t_state;

    t_state                       r_state,    n_state;
    logic [ROT_W-1:0]             r_rot_cnt,  n_rot_cnt;
    logic [tvs_pkg::TURN_K_W-1:0] r_turn_k,   n_turn_k;
    logic                         r_m_valid,  n_m_valid;

    always_comb begin
        n_state   = r_state;
        n_rot_cnt = r_rot_cnt;
        n_turn_k  = r_turn_k;
        n_m_valid = r_m_valid & ~i_m_tready;
        o_cmd     = '0;
        o_cmd.turn_k = r_turn_k;

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    case (i_op)
                        tvs_pkg::OP_TURN: n_state = S_TINIT;
                        tvs_pkg::OP_MOVE: n_state = S_BAM1;
                        default:          n_state = S_FIN;
                    endcase
                end
            end
            S_TINIT: begin
                o_cmd.turn_init = 1'b1;
                n_turn_k        = tvs_pkg::TURN_K_W'(tvs_pkg::TURN_STEPS - 1);
                n_state         = S_TURN;
            end
            S_TURN: begin
                o_cmd.turn_step = 1'b1;
                if (r_turn_k == '0) begin
                    n_state = S_FIN;
                end else begin
                    n_turn_k = r_turn_k - 1'b1;
                end
            end
            S_BAM1: begin
                o_cmd.bam_mul = 1'b1;
                n_state       = S_BAM2;
            end
            S_BAM2: begin
                o_cmd.bam_chk = 1'b1;
                n_state       = S_BAM3;
            end
            S_BAM3: begin
                o_cmd.bam_fix = 1'b1;
                n_state       = S_INIT;
            end
            S_INIT: begin
                o_cmd.rot_init = 1'b1;
                n_rot_cnt      = '0;
                n_state        = S_ROT;
            end
            S_ROT: begin
                o_cmd.rot_step = 1'b1;
                if (r_rot_cnt == ROT_W'(CORDIC_ITERATIONS - 1)) begin
                    n_state = S_MULX;
                end else begin
                    n_rot_cnt = r_rot_cnt + 1'b1;
                end
            end
            S_MULX: begin
                o_cmd.mul_x = 1'b1;
                n_state     = S_MULY;
            end
            S_MULY: begin
                o_cmd.mul_y = 1'b1;
                o_cmd.add_x = 1'b1;
                n_state     = S_ADDY;
            end
            S_ADDY: begin
                o_cmd.add_y = 1'b1;
                n_state     = S_FIN;
            end
            S_FIN: begin
                // The result register is free when empty or drained this cycle.
                if (!r_m_valid || i_m_tready) begin
                    o_cmd.out_load = 1'b1;
                    n_m_valid      = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rot_cnt <= '0;
            r_turn_k  <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rot_cnt <= n_rot_cnt;
            r_turn_k  <= n_turn_k;
            r_m_valid <= n_m_valid;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_rot_idx  = r_rot_cnt;

endmodule

FILE: src/tvs_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Turtle vector stepper datapath
// Turtle state, heading reduction, angle conversion, CORDIC rotation,
// displacement and the result register.
// ----------------------------------------------------------------------------
module tvs_dp #(
    parameter int CORDIC_ITERATIONS = 16,
    localparam int ROT_W = $clog2(CORDIC_ITERATIONS)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tvs_pkg::t_dp_cmd                  i_cmd,
    input  logic [ROT_W-1:0]                  i_rot_idx,
    input  logic [tvs_pkg::OP_W-1:0]          i_op,
    input  logic signed [tvs_pkg::AMT_W-1:0]  i_amount,
    output logic                              o_prev_pen,
    output logic [tvs_pkg::HDG_W-1:0]         o_heading,
    output logic signed [tvs_pkg::POS_W-1:0]  o_x,
    output logic signed [tvs_pkg::POS_W-1:0]  o_y,
    output logic signed [tvs_pkg::POS_W-1:0]  o_from_x,
    output logic signed [tvs_pkg::POS_W-1:0]  o_from_y,
    output logic                              o_line_drawn,
    output logic                              o_clear_req
);

    localparam int POS_W   = tvs_pkg::POS_W;
    localparam int SUM_W   = POS_W + 1;
    localparam int CX_W    = tvs_pkg::CX_W;
    localparam int QSH     = tvs_pkg::RECIP_SHIFT - tvs_pkg::BAM_W;
    localparam int ACC_W   = tvs_pkg::TURN_ACC_W;
    localparam int DPROD_W = tvs_pkg::DPROD_W;

    localparam logic signed [CX_W-1:0] Z_QUARTER = CX_W'(longint'(1) << 30);
    localparam logic signed [CX_W-1:0] Z_HALF    = CX_W'(longint'(1) << 31);
    localparam logic signed [CX_W-1:0] Z_NQUARTER = -Z_QUARTER;

    // Turtle state.
    logic signed [POS_W-1:0]          r_x;
    logic signed [POS_W-1:0]          r_y;
    logic [tvs_pkg::HDG_W-1:0]        r_hdg;
    logic                             r_pen;

    // Per-command working registers.
    logic signed [tvs_pkg::AMT_W-1:0] r_amt;
    logic                             r_prev_pen;
    logic                             r_drawn;
    logic                             r_clr;
    logic signed [POS_W-1:0]          r_from_x;
    logic signed [POS_W-1:0]          r_from_y;
    logic [ACC_W-1:0]                 r_acc;
    logic [tvs_pkg::BPROD_W-1:0]      r_bprod;
    logic [tvs_pkg::BAM_W-1:0]        r_q;
    logic [tvs_pkg::QFT_W-1:0]        r_qft;
    logic signed [CX_W-1:0]           r_cx;
    logic signed [CX_W-1:0]           r_cy;
    logic signed [CX_W-1:0]           r_cz;
    logic signed [tvs_pkg::MAMT_W-1:0] r_mamt;
    logic signed [DPROD_W-1:0]        r_prod;

    logic [ACC_W-1:0]                 w_sub;
    logic [ACC_W-1:0]                 w_acc_next;
    logic [tvs_pkg::BAM_W-1:0]        w_qest;
    logic [tvs_pkg::QFT_W-1:0]        w_rem;
    logic signed [CX_W-1:0]           w_z0;
    logic signed [CX_W-1:0]           w_zf;
    logic                             w_neg;
    logic signed [CX_W-1:0]           w_sx;
    logic signed [CX_W-1:0]           w_sy;
    logic signed [CX_W-1:0]           w_atan;
    logic signed [CX_W-1:0]           w_mop;
    logic signed [DPROD_W-1:0]        w_rnd;
    logic signed [tvs_pkg::DX_W-1:0]  w_d;
    logic signed [SUM_W-1:0]          w_sum_x;
    logic signed [SUM_W-1:0]          w_sum_y;

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
        logic signed [POS_W-1:0] r;
        if (v[SUM_W-1] != v[SUM_W-2]) begin
            r = v[SUM_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end else begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

    // Heading reduction step.
    always_comb begin
        w_sub      = ACC_W'(tvs_pkg::FULL_TURN) << i_cmd.turn_k;
        w_acc_next = (r_acc >= w_sub) ? (r_acc - w_sub) : r_acc;
    end

    // Angle conversion: estimate is low by at most one.
    assign w_qest = r_bprod[QSH +: tvs_pkg::BAM_W];
    assign w_rem  = {r_hdg, tvs_pkg::BAM_W'(0)} - r_qft;

    // Fold the angle into the right half plane; the result is negated then.
    always_comb begin
        w_z0  = CX_W'($signed(r_q));
        w_zf  = w_z0;
        w_neg = 1'b0;
        if (w_z0 > Z_QUARTER) begin
            w_zf  = w_z0 - Z_HALF;
            w_neg = 1'b1;
        end else if (w_z0 < Z_NQUARTER) begin
            w_zf  = w_z0 + Z_HALF;
            w_neg = 1'b1;
        end
    end

    assign w_sx   = r_cx >>> i_rot_idx;
    assign w_sy   = r_cy >>> i_rot_idx;
    assign w_atan = CX_W'(tvs_pkg::atan_bam(tvs_pkg::ATAN_IDX_W'(i_rot_idx)));

    // Displacement: round half up, then add with saturation.
    assign w_mop   = i_cmd.mul_y ? r_cy : r_cx;
    assign w_rnd   = r_prod + (DPROD_W'(1) <<< (tvs_pkg::ROUND_SHIFT - 1));
    assign w_d     = w_rnd[DPROD_W-1:tvs_pkg::ROUND_SHIFT];
    assign w_sum_x = SUM_W'(r_x) + SUM_W'(w_d);
    assign w_sum_y = SUM_W'(r_y) + SUM_W'(w_d);

    // Architectural turtle state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x   <= '0;
            r_y   <= '0;
            r_hdg <= '0;
            r_pen <= 1'b1;
        end else begin
            if (i_cmd.load) begin
                case (i_op)
                    tvs_pkg::OP_RESET, tvs_pkg::OP_CENTER: begin
                        r_x   <= '0;
                        r_y   <= '0;
                        r_hdg <= '0;
                        r_pen <= 1'b1;
                    end
                    tvs_pkg::OP_PEN_UP:   r_pen <= 1'b0;
                    tvs_pkg::OP_PEN_DOWN: r_pen <= 1'b1;
                    default: ;
                endcase
            end
            if (i_cmd.turn_step && i_cmd.turn_k == '0) begin
                r_hdg <= w_acc_next[tvs_pkg::HDG_W-1:0];
            end
            if (i_cmd.add_x) begin
                r_x <= sat_pos(w_sum_x);
            end
            if (i_cmd.add_y) begin
                r_y <= sat_pos(w_sum_y);
            end
        end
    end

    // Working registers and result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_amt      <= i_amount;
            r_prev_pen <= r_pen;
            r_clr      <= (i_op == tvs_pkg::OP_RESET);
            r_drawn    <= (i_op == tvs_pkg::OP_MOVE) & r_pen;
            r_from_x   <= (i_op == tvs_pkg::OP_MOVE) ? r_x : '0;
            r_from_y   <= (i_op == tvs_pkg::OP_MOVE) ? r_y : '0;
        end
        if (i_cmd.turn_init) begin
            r_acc <= ACC_W'(r_hdg) + ACC_W'(r_amt) + ACC_W'(tvs_pkg::TURN_BIAS);
        end
        if (i_cmd.turn_step) begin
            r_acc <= w_acc_next;
        end
        if (i_cmd.bam_mul) begin
            // The reciprocal has its top bit set, so it is widened as unsigned.
            r_bprod <= tvs_pkg::BPROD_W'(r_hdg)
                     * tvs_pkg::BPROD_W'($unsigned(tvs_pkg::RECIP_W'(tvs_pkg::RECIP)));
        end
        if (i_cmd.bam_chk) begin
            r_q   <= w_qest;
            r_qft <= tvs_pkg::QFT_W'(w_qest) * tvs_pkg::QFT_W'(tvs_pkg::FULL_TURN);
        end
        if (i_cmd.bam_fix) begin
            if (w_rem >= tvs_pkg::QFT_W'(tvs_pkg::FULL_TURN)) begin
                r_q <= r_q + 1'b1;
            end
        end
        if (i_cmd.rot_init) begin
            r_cx   <= CX_W'(tvs_pkg::CORDIC_START);
            r_cy   <= '0;
            r_cz   <= w_zf;
            r_mamt <= w_neg ? -tvs_pkg::MAMT_W'(r_amt) : tvs_pkg::MAMT_W'(r_amt);
        end
        if (i_cmd.rot_step) begin
            if (!r_cz[CX_W-1]) begin
                r_cx <= r_cx - w_sy;
                r_cy <= r_cy + w_sx;
                r_cz <= r_cz - w_atan;
            end else begin
                r_cx <= r_cx + w_sy;
                r_cy <= r_cy - w_sx;
                r_cz <= r_cz + w_atan;
            end
        end
        if (i_cmd.mul_x || i_cmd.mul_y) begin
            r_prod <= DPROD_W'(r_mamt) * DPROD_W'(w_mop);
        end
        if (i_cmd.out_load) begin
            o_prev_pen   <= r_prev_pen;
            o_heading    <= r_hdg;
            o_x          <= r_x;
            o_y          <= r_y;
            o_from_x     <= r_from_x;
            o_from_y     <= r_from_y;
            o_line_drawn <= r_drawn;
            o_clear_req  <= r_clr;
        end
    end

endmodule

FILE: src/turtle_vector_stepper_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Turtle vector stepper top level
// Turtle-graphics command engine with a CORDIC-based relative move.
// ----------------------------------------------------------------------------
// The block takes one command per input transaction and returns exactly one
// result transaction for it, describing the turtle after the command. Commands
// are executed one at a time. Reset, center, pen up, pen down and unknown codes
// go straight to the result write; a turn first runs eight conditional subtracts
// that bring the heading back into one turn, and a move first runs angle
// conversion, the CORDIC rotation loop, which runs one iteration per clock,
// and the two displacement multiplies that share one multiplier. The result
// sits in an output register, so a new command is taken while the previous
// result still waits; only the final write of a result waits for that
// register to drain.
// ----------------------------------------------------------------------------
module turtle_vector_stepper_top #(
    // Number of CORDIC rotation steps per move, 8 to 30.
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Command channel.
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // tdata: amount [23:0], signed degrees or length, 8 fraction bits.
    input  logic [23:0]  i_s_tdata,
    // tuser: operation [2:0].
    input  logic [2:0]   i_s_tuser,
    // Result channel.
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // tdata: prev_pen [0], out_heading [17:1], out_x [49:18], out_y [81:50],
    // line_from_x [113:82], line_from_y [145:114], zero fill [151:146].
    output logic [151:0] o_m_tdata,
    // tuser: line_drawn [0], clear_requested [1].
    output logic [1:0]   o_m_tuser
);

    localparam int ROT_W = $clog2(CORDIC_ITERATIONS);
    localparam int M_FIELDS_W = 1 + tvs_pkg::HDG_W + 4 * tvs_pkg::POS_W;
    localparam int M_PAD_W    = 152 - M_FIELDS_W;

    tvs_pkg::t_dp_cmd                 w_cmd;
    logic [ROT_W-1:0]                 w_rot_idx;
    logic                             w_prev_pen;
    logic [tvs_pkg::HDG_W-1:0]        w_heading;
    logic signed [tvs_pkg::POS_W-1:0] w_x;
    logic signed [tvs_pkg::POS_W-1:0] w_y;
    logic signed [tvs_pkg::POS_W-1:0] w_from_x;
    logic signed [tvs_pkg::POS_W-1:0] w_from_y;
    logic                             w_line_drawn;
    logic                             w_clear_req;

    // The controller owns the handshakes and steps the datapath.
    tvs_ctrl #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_op       (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (w_cmd),
        .o_rot_idx  (w_rot_idx)
    );

    // The datapath holds the turtle state and the result register.
    tvs_dp #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_rot_idx    (w_rot_idx),
        .i_op         (i_s_tuser),
        .i_amount     ($signed(i_s_tdata)),
        .o_prev_pen   (w_prev_pen),
        .o_heading    (w_heading),
        .o_x          (w_x),
        .o_y          (w_y),
        .o_from_x     (w_from_x),
        .o_from_y     (w_from_y),
        .o_line_drawn (w_line_drawn),
        .o_clear_req  (w_clear_req)
    );

    // Result fields packed from the lowest bit up.
    assign o_m_tdata = {{M_PAD_W{1'b0}}, w_from_y, w_from_x, w_y, w_x, w_heading, w_prev_pen};
    assign o_m_tuser = {w_clear_req, w_line_drawn};

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Turtle vector stepper testbench
// Sends turtle commands through the command stream, keeps an independent
// model of the turtle (position, heading, pen and the CORDIC move) and
// checks every result transaction against it, field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;

    // Clock period is 12 ns.
    localparam int CLK_HALF         = 6;
    localparam int RESET_CYCLES     = 4;
    localparam int STALL_LIMIT      = 2000;
    localparam int SETTLE_CYCLES    = 40;
    localparam int RANDOM_PER_PHASE = 150;
    localparam int REPORT_LIMIT     = 10;

    // A move at 45 degrees advances about 0.707 * 2^23 per step, so this many
    // full-length steps carry both coordinates past the 32-bit limits.
    localparam int SAT_MOVES = 370;

    // Codes 6 and 7 are not commands; the block must leave the turtle alone.
    localparam logic [tvs_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [tvs_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;

    localparam logic signed [tvs_pkg::AMT_W-1:0] AMT_MAX = 24'sh7FFFFF;
    localparam logic signed [tvs_pkg::AMT_W-1:0] AMT_MIN = 24'sh800000;

    // One degree in heading units, and one full turn.
    localparam int     DEG         = 1 << tvs_pkg::FRACTION_BITS;
    localparam longint HEADING_MOD = longint'(360) << tvs_pkg::FRACTION_BITS;

    localparam int     CORDIC_STEPS = 16;
    localparam longint UNIT_GAIN    = 652032874;
    localparam longint POS_MAX      = 64'sd2147483647;
    localparam longint POS_MIN      = -64'sd2147483648;

    typedef struct {
        logic                             prev_pen;
        logic [tvs_pkg::HDG_W-1:0]        heading;
        logic signed [tvs_pkg::POS_W-1:0] x;
        logic signed [tvs_pkg::POS_W-1:0] y;
        logic signed [tvs_pkg::POS_W-1:0] from_x;
        logic signed [tvs_pkg::POS_W-1:0] from_y;
        logic [5:0]                       fill;
        logic                             drawn;
        logic                             clear;
    } t_turtle_result;

    logic         i_clk   = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [23:0]  s_tdata  = '0;
    logic [2:0]   s_tuser  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [151:0] m_tdata;
    logic [1:0]   m_tuser;

    // Turtle as the testbench sees it.
    logic signed [tvs_pkg::POS_W-1:0] turtle_x;
    logic signed [tvs_pkg::POS_W-1:0] turtle_y;
    logic [tvs_pkg::HDG_W-1:0]        turtle_heading;
    logic                             turtle_pen;

    // Arctangent of 2^-i in binary-angle units (2^32 per turn).
    longint atan_units [0:29] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1
    };

    t_turtle_result turtle_results [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatch_count = 0;
    int results_seen = 0;
    int commands_sent = 0;
    int moves_sent = 0;
    int turns_sent = 0;
    int lines_drawn = 0;
    int clamped_results = 0;
    int stall_cycles = 0;

    turtle_vector_stepper_top #(
        .CORDIC_ITERATIONS(CORDIC_STEPS)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(s_tready),
        .i_s_tdata (s_tdata),
        .i_s_tuser (s_tuser),
        .o_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata (m_tdata),
        .o_m_tuser (m_tuser)
    );

    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Turtle model
    // ------------------------------------------------------------------------

    // Unit vector of a heading in Q30. The heading becomes a binary angle,
    // is folded into [-90, 90] degrees, and is then rotated step by step.
    function automatic void heading_unit_vector(input logic [tvs_pkg::HDG_W-1:0] hdg,
                                                output longint cos_q30,
                                                output longint sin_q30);
        longint angle;
        longint vx;
        longint vy;
        longint nx;
        bit     flipped;
        int     i;
        angle = ((longint'(hdg) << 32) / HEADING_MOD) & 64'hFFFF_FFFF;
        vx = UNIT_GAIN;
        vy = 0;
        flipped = 1'b0;
        if (angle >= (longint'(1) << 31))
            angle -= longint'(1) << 32;
        if (angle > (longint'(1) << 30)) begin
            angle -= longint'(1) << 31;
            flipped = 1'b1;
        end else if (angle < -(longint'(1) << 30)) begin
            angle += longint'(1) << 31;
            flipped = 1'b1;
        end
        for (i = 0; i < CORDIC_STEPS && i < 30; i++) begin
            if (angle >= 0) begin
                nx = vx - (vy >>> i);
                vy = vy + (vx >>> i);
                angle -= atan_units[i];
            end else begin
                nx = vx + (vy >>> i);
                vy = vy - (vx >>> i);
                angle += atan_units[i];
            end
            vx = nx;
        end
        cos_q30 = flipped ? -vx : vx;
        sin_q30 = flipped ? -vy : vy;
    endfunction

    function automatic logic signed [tvs_pkg::POS_W-1:0] clamp_position(input longint v);
        if (v > POS_MAX)
            return POS_MAX[tvs_pkg::POS_W-1:0];
        if (v < POS_MIN)
            return POS_MIN[tvs_pkg::POS_W-1:0];
        return v[tvs_pkg::POS_W-1:0];
    endfunction

    // Applies one command to the turtle and returns the result it must cause.
    function automatic t_turtle_result apply_turtle_command(
        input logic [tvs_pkg::OP_W-1:0] op, input logic signed [tvs_pkg::AMT_W-1:0] amt);
        t_turtle_result r;
        longint cos_q30;
        longint sin_q30;
        longint step_x;
        longint step_y;
        longint hdg_sum;
        r.prev_pen = turtle_pen;
        r.from_x   = '0;
        r.from_y   = '0;
        r.fill     = '0;
        r.drawn    = 1'b0;
        r.clear    = 1'b0;
        case (op)
            tvs_pkg::OP_RESET, tvs_pkg::OP_CENTER: begin
                r.clear        = (op == tvs_pkg::OP_RESET);
                turtle_x       = '0;
                turtle_y       = '0;
                turtle_heading = '0;
                turtle_pen     = 1'b1;
            end
            tvs_pkg::OP_PEN_UP:   turtle_pen = 1'b0;
            tvs_pkg::OP_PEN_DOWN: turtle_pen = 1'b1;
            tvs_pkg::OP_TURN: begin
                hdg_sum = (longint'(turtle_heading) + longint'(amt)) % HEADING_MOD;
                if (hdg_sum < 0)
                    hdg_sum += HEADING_MOD;
                turtle_heading = hdg_sum[tvs_pkg::HDG_W-1:0];
            end
            tvs_pkg::OP_MOVE: begin
                heading_unit_vector(turtle_heading, cos_q30, sin_q30);
                step_x   = (longint'(amt) * cos_q30 + (longint'(1) << 29)) >>> 30;
                step_y   = (longint'(amt) * sin_q30 + (longint'(1) << 29)) >>> 30;
                r.from_x = turtle_x;
                r.from_y = turtle_y;
                r.drawn  = turtle_pen;
                turtle_x = clamp_position(longint'(turtle_x) + step_x);
                turtle_y = clamp_position(longint'(turtle_y) + step_y);
            end
            default: ;
        endcase
        r.heading = turtle_heading;
        r.x       = turtle_x;
        r.y       = turtle_y;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------------

    // Offers one command, with random idle cycles in front of it, and records
    // the expected result once the transaction has been accepted. The valid
    // stays high so that back-to-back commands leave no gap.
    task automatic send_command(input logic [tvs_pkg::OP_W-1:0] op,
                                input logic signed [tvs_pkg::AMT_W-1:0] amt);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= amt;
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        turtle_results.push_back(apply_turtle_command(op, amt));
        commands_sent++;
        if (op == tvs_pkg::OP_MOVE)
            moves_sent++;
        if (op == tvs_pkg::OP_TURN)
            turns_sent++;
    endtask

    // Holds the command stream off until every outstanding result is back.
    // The queue is polled on the falling edge so that it never races the
    // checker, then the task realigns to the rising edge.
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (turtle_results.size() != 0)
            @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Every command once, the pen in both states, headings on the quadrant
    // boundaries, turns that wrap several times, and the longest moves.
    task automatic test_directed_commands();
        send_command(tvs_pkg::OP_PEN_UP, '0);
        send_command(tvs_pkg::OP_PEN_UP, '0);
        send_command(tvs_pkg::OP_PEN_DOWN, '0);
        send_command(tvs_pkg::OP_PEN_DOWN, '0);
        send_command(tvs_pkg::OP_MOVE, AMT_MAX);
        send_command(tvs_pkg::OP_TURN, 24'(90 * DEG));
        send_command(tvs_pkg::OP_MOVE, AMT_MIN);
        send_command(tvs_pkg::OP_TURN, 24'(90 * DEG));
        send_command(tvs_pkg::OP_MOVE, 24'sd1000);
        send_command(tvs_pkg::OP_TURN, 24'(90 * DEG));
        send_command(tvs_pkg::OP_MOVE, AMT_MAX);
        send_command(tvs_pkg::OP_TURN, AMT_MAX);
        send_command(tvs_pkg::OP_TURN, AMT_MIN);
        send_command(tvs_pkg::OP_TURN, '0);
        send_command(tvs_pkg::OP_PEN_UP, '0);
        send_command(tvs_pkg::OP_MOVE, 24'sd12345);
        send_command(OP_SPARE_6, AMT_MAX);
        send_command(OP_SPARE_7, -24'sd1);
        send_command(tvs_pkg::OP_CENTER, '0);
        // Just below a full turn, then a small step that barely rounds.
        send_command(tvs_pkg::OP_TURN, -24'sd1);
        send_command(tvs_pkg::OP_MOVE, 24'sd1);
        send_command(tvs_pkg::OP_MOVE, -24'sd1);
        send_command(tvs_pkg::OP_MOVE, '0);
        send_command(tvs_pkg::OP_RESET, '0);
        wait_results_drained();
    endtask

    // Drives the turtle diagonally at 315 degrees, so that x clamps at the
    // upper limit and y at the lower one, then steps back once from the
    // clamped corner and out again.
    task automatic test_position_saturation();
        int n;
        send_command(tvs_pkg::OP_CENTER, '0);
        send_command(tvs_pkg::OP_TURN, -24'(45 * DEG));
        for (n = 0; n < SAT_MOVES; n++)
            send_command(tvs_pkg::OP_MOVE, AMT_MAX);
        send_command(tvs_pkg::OP_MOVE, AMT_MIN);
        send_command(tvs_pkg::OP_MOVE, AMT_MAX);
        send_command(tvs_pkg::OP_RESET, '0);
        wait_results_drained();
    endtask

    // Random command mix, weighted toward moves and turns. Amounts are full
    // random words, small values, the field extremes, or multiples of 45
    // degrees so that headings land on the CORDIC fold points.
    task automatic test_random_commands(input int count);
        int                                  n;
        int                                  pick;
        logic [tvs_pkg::OP_W-1:0]            op;
        logic signed [tvs_pkg::AMT_W-1:0]    amt;
        for (n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 40)
                op = tvs_pkg::OP_MOVE;
            else if (pick < 65)
                op = tvs_pkg::OP_TURN;
            else if (pick < 75)
                op = tvs_pkg::OP_PEN_UP;
            else if (pick < 85)
                op = tvs_pkg::OP_PEN_DOWN;
            else if (pick < 90)
                op = tvs_pkg::OP_CENTER;
            else if (pick < 94)
                op = tvs_pkg::OP_RESET;
            else if (pick < 97)
                op = OP_SPARE_6;
            else
                op = OP_SPARE_7;
            case ($urandom_range(3))
                0: amt = 24'($urandom);
                1: amt = 24'($urandom_range(8191)) - 24'd4096;
                2: begin
                    case ($urandom_range(4))
                        0: amt = AMT_MAX;
                        1: amt = AMT_MIN;
                        2: amt = '0;
                        3: amt = 24'sd1;
                        default: amt = -24'sd1;
                    endcase
                end
                default: amt = 24'((int'($urandom_range(16)) - 8) * 45 * DEG);
            endcase
            send_command(op, amt);
            if ($urandom_range(63) == 0)
                wait_results_drained();
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------

    task automatic check_field(input string field, input longint want_v,
                               input longint got_v);
        if (want_v != got_v) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("Result %0d: %s mismatch, expected %0d, got %0d",
                         results_seen, field, want_v, got_v);
        end
    endtask

    // Takes each result transaction, compares it with the oldest outstanding
    // expectation, and draws a fresh random ready for the next edge.
    always @(posedge i_clk) begin : result_checker
        t_turtle_result want;
        t_turtle_result got;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.prev_pen = m_tdata[0];
            got.heading  = m_tdata[17:1];
            got.x        = m_tdata[49:18];
            got.y        = m_tdata[81:50];
            got.from_x   = m_tdata[113:82];
            got.from_y   = m_tdata[145:114];
            got.fill     = m_tdata[151:146];
            got.drawn    = m_tuser[0];
            got.clear    = m_tuser[1];
            if (turtle_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("Result %0d arrived with no command outstanding",
                             results_seen);
            end else begin
                want = turtle_results.pop_front();
                check_field("prev_pen", want.prev_pen, got.prev_pen);
                check_field("out_heading", want.heading, got.heading);
                check_field("out_x", want.x, got.x);
                check_field("out_y", want.y, got.y);
                check_field("line_from_x", want.from_x, got.from_x);
                check_field("line_from_y", want.from_y, got.from_y);
                check_field("zero fill", want.fill, got.fill);
                check_field("line_drawn", want.drawn, got.drawn);
                check_field("clear_requested", want.clear, got.clear);
                if (want.drawn)
                    lines_drawn++;
                if (longint'(want.x) == POS_MAX || longint'(want.x) == POS_MIN ||
                    longint'(want.y) == POS_MAX || longint'(want.y) == POS_MIN)
                    clamped_results++;
            end
            results_seen++;
        end
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Ends the run if neither stream has moved a transaction for too long.
    always @(posedge i_clk) begin
        if (i_rst_n && ((s_tvalid && s_tready) || (m_tvalid && m_tready)))
            stall_cycles = 0;
        else if (i_rst_n)
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
                     stall_cycles, turtle_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        turtle_x       = '0;
        turtle_y       = '0;
        turtle_heading = '0;
        turtle_pen     = 1'b1;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sender mostly busy, receiver often stalling.
        send_idle_pct = 11;
        recv_idle_pct = 69;
        test_directed_commands();
        test_random_commands(RANDOM_PER_PHASE);

        // Sender often idle, receiver mostly ready.
        send_idle_pct = 69;
        recv_idle_pct = 11;
        test_position_saturation();
        test_random_commands(RANDOM_PER_PHASE);

        // Both sides at full rate.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_commands(RANDOM_PER_PHASE);

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (turtle_results.size() != 0) begin
            mismatch_count++;
            $display("%0d expected results never arrived", turtle_results.size());
        end

        $display("Covered %0d commands (%0d moves, %0d turns), %0d results checked",
                 commands_sent, moves_sent, turns_sent, results_seen);
        $display("Segments drawn: %0d, results with a clamped coordinate: %0d, mismatches: %0d",
                 lines_drawn, clamped_results, mismatch_count);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
